FILE: src/sqvg_pkg.sv
// ----------------------------------------------------------------------------
// sqvg_pkg: shared types and constants of the sphere quad vertex generator
// Widths, register indexes, reset values, stage records and the builder of
// the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package sqvg_pkg;

  // Sizes
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int INDEX_BITS       = 10;
  localparam int ANGLE_W          = 16;
  localparam int COORD_W          = 16;
  localparam int MAG_W            = 15;
  localparam int RADIUS_W         = 15;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int CORNER_W         = 2;
  localparam int QUEUE_DEPTH      = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLAR_STEP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AZIMUTH_STEP = 2'd2;

  // Register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RESET       = 15'd16384;
  localparam logic [ANGLE_W-1:0]  POLAR_STEP_RESET   = 16'd328;
  localparam logic [ANGLE_W-1:0]  AZIMUTH_STEP_RESET = 16'd655;

  localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd3;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Angles of one quad: two polar and two azimuth angles
  typedef struct packed {
    logic [ANGLE_W-1:0] p0;
    logic [ANGLE_W-1:0] p1;
    logic [ANGLE_W-1:0] a0;
    logic [ANGLE_W-1:0] a1;
  } angles_t;

  typedef logic signed [COORD_W-1:0] trig_val_t;

  // Signed sine and cosine of the four angles of one quad
  typedef struct packed {
    trig_val_t sp0;
    trig_val_t cp0;
    trig_val_t sp1;
    trig_val_t cp1;
    trig_val_t sa0;
    trig_val_t ca0;
    trig_val_t sa1;
    trig_val_t ca1;
  } trig_set_t;

  // Hand-over from the lookup sequencer to the vertex datapath
  typedef struct packed {
    logic      load;
    trig_set_t set;
  } trig_load_t;

  typedef logic [MAG_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine table, 11th order Taylor series in Q30
  function automatic sine_rom_t build_sine_table();
    sine_rom_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k] = MAG_W'(v);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

FILE: src/sqvg_front.sv
// ----------------------------------------------------------------------------
// sqvg_front: input side of the sphere quad vertex generator
// Holds the configuration registers, takes quad items and turns ring and
// segment indexes into the quad's polar and azimuth angles for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [sqvg_pkg::INDEX_BITS-1:0]      ring_index_i,
  input  wire logic [sqvg_pkg::INDEX_BITS-1:0]      segment_index_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [sqvg_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [sqvg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [sqvg_pkg::RADIUS_W-1:0]             radius_o,
  input  wire logic                                 queue_full_i,
  output logic                                      push_o,
  output sqvg_pkg::angles_t                         push_data_o
);

  localparam int PROD_W = sqvg_pkg::INDEX_BITS + sqvg_pkg::ANGLE_W;

  logic [sqvg_pkg::RADIUS_W-1:0] radius_q;
  logic [sqvg_pkg::ANGLE_W-1:0]  polar_step_q;
  logic [sqvg_pkg::ANGLE_W-1:0]  azimuth_step_q;
  logic [PROD_W-1:0]             polar_prod;
  logic [PROD_W-1:0]             azimuth_prod;
  logic [sqvg_pkg::ANGLE_W-1:0]  p0;
  logic [sqvg_pkg::ANGLE_W-1:0]  a0;

  // Configuration writes, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q       <= sqvg_pkg::RADIUS_RESET;
      polar_step_q   <= sqvg_pkg::POLAR_STEP_RESET;
      azimuth_step_q <= sqvg_pkg::AZIMUTH_STEP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sqvg_pkg::REG_RADIUS: begin
          radius_q <= cfg_data_i[sqvg_pkg::RADIUS_W-1:0];
        end
        sqvg_pkg::REG_POLAR_STEP: begin
          polar_step_q <= cfg_data_i;
        end
        sqvg_pkg::REG_AZIMUTH_STEP: begin
          azimuth_step_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign radius_o = radius_q;

  // Hold input while the queue is full
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Angles wrap modulo one turn
  assign polar_prod   = PROD_W'(ring_index_i) * PROD_W'(polar_step_q);
  assign azimuth_prod = PROD_W'(segment_index_i) * PROD_W'(azimuth_step_q);
  assign p0 = polar_prod[sqvg_pkg::ANGLE_W-1:0];
  assign a0 = azimuth_prod[sqvg_pkg::ANGLE_W-1:0];

  assign push_data_o.p0 = p0;
  assign push_data_o.p1 = p0 + polar_step_q;
  assign push_data_o.a0 = a0;
  assign push_data_o.a1 = a0 + azimuth_step_q;

endmodule

`default_nettype wire

FILE: src/sqvg_queue.sv
// ----------------------------------------------------------------------------
// sqvg_queue: short queue between front and back
// Buffers quad angle records so the input side keeps taking items while
// the back end is stalled, until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sqvg_pkg::angles_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   head_valid_o,
  output sqvg_pkg::angles_t      head_data_o
);

  localparam int PTR_W = (sqvg_pkg::QUEUE_DEPTH > 1) ? $clog2(sqvg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sqvg_pkg::QUEUE_DEPTH + 1);

  sqvg_pkg::angles_t slot_q [sqvg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_d;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(sqvg_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  assign full_o       = (count_q == CNT_W'(sqvg_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/sqvg_lookup.sv
// ----------------------------------------------------------------------------
// sqvg_lookup: sine and cosine lookup sequencer
// Pops one quad record and reads its eight sine and cosine values from the
// quarter-wave table over four slots, two reads per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_lookup (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               head_valid_i,
  input  wire sqvg_pkg::angles_t  head_data_i,
  output logic                    pop_o,
  output sqvg_pkg::trig_load_t    trig_o
);

  localparam int ANGLE_W = sqvg_pkg::ANGLE_W;
  localparam int PHASE_W = ANGLE_W - 2;
  localparam int ADDR_W  = $clog2(sqvg_pkg::SINE_TABLE_DEPTH + 1);
  localparam int SCALE_W = PHASE_W + ADDR_W;
  localparam int MAG_W   = sqvg_pkg::MAG_W;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(1) << PHASE_W;

  localparam sqvg_pkg::sine_rom_t SINE_ROM = sqvg_pkg::build_sine_table();

  typedef enum logic [3:0] {
    SLOT_AZ0  = 4'b0001,
    SLOT_POL0 = 4'b0010,
    SLOT_POL1 = 4'b0100,
    SLOT_AZ1  = 4'b1000
  } slot_e;

  sqvg_pkg::angles_t   cur_q;
  sqvg_pkg::angles_t   cur_d;
  logic                busy_q;
  logic                busy_d;
  slot_e               slot_q;
  slot_e               slot_d;
  logic [ANGLE_W-1:0]  angle;
  logic [ADDR_W:0]     sin_ref;
  logic [ADDR_W:0]     cos_ref;
  logic [MAG_W-1:0]    sin_mag_q;
  logic [MAG_W-1:0]    cos_mag_q;
  logic                sin_neg_q;
  logic                cos_neg_q;
  logic                rd_valid_q;
  slot_e               rd_slot_q;
  sqvg_pkg::trig_val_t sin_val;
  sqvg_pkg::trig_val_t cos_val;
  sqvg_pkg::trig_val_t sp0_q;
  sqvg_pkg::trig_val_t cp0_q;
  sqvg_pkg::trig_val_t sp1_q;
  sqvg_pkg::trig_val_t cp1_q;
  sqvg_pkg::trig_val_t sa0_q;
  sqvg_pkg::trig_val_t ca0_q;

  // Table address and sign of an angle: {negate, address}
  function automatic logic [ADDR_W:0] rom_ref(input logic [ANGLE_W-1:0] ang);
    logic [SCALE_W-1:0] scaled;
    logic [ADDR_W-1:0]  idx;
    scaled = SCALE_W'(ang[PHASE_W-1:0]) * SCALE_W'(sqvg_pkg::SINE_TABLE_DEPTH);
    idx    = scaled[PHASE_W +: ADDR_W];
    if (ang[ANGLE_W-2]) begin
      idx = ADDR_W'(sqvg_pkg::SINE_TABLE_DEPTH) - idx;
    end
    return {ang[ANGLE_W-1], idx};
  endfunction

  function automatic sqvg_pkg::trig_val_t apply_sign(input logic neg, input logic [MAG_W-1:0] mag);
    sqvg_pkg::trig_val_t v;
    v = sqvg_pkg::trig_val_t'({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // Take the next quad as the last slot of the current one goes out
  assign pop_o = adv_i && head_valid_i && (!busy_q || (slot_q == SLOT_AZ1));

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    cur_d  = cur_q;
    if (adv_i && busy_q) begin
      case (slot_q)
        SLOT_AZ0:  slot_d = SLOT_POL0;
        SLOT_POL0: slot_d = SLOT_POL1;
        SLOT_POL1: slot_d = SLOT_AZ1;
        SLOT_AZ1: begin
          slot_d = SLOT_AZ0;
          busy_d = 1'b0;
        end
        default:   slot_d = SLOT_AZ0;
      endcase
    end
    if (pop_o) begin
      busy_d = 1'b1;
      slot_d = SLOT_AZ0;
      cur_d  = head_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      slot_q     <= SLOT_AZ0;
      rd_valid_q <= 1'b0;
      rd_slot_q  <= SLOT_AZ0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
      if (adv_i) begin
        rd_valid_q <= busy_q;
        rd_slot_q  <= slot_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Angle read in this slot
  always_comb begin
    case (slot_q)
      SLOT_AZ0:  angle = cur_q.a0;
      SLOT_POL0: angle = cur_q.p0;
      SLOT_POL1: angle = cur_q.p1;
      SLOT_AZ1:  angle = cur_q.a1;
      default:   angle = cur_q.a0;
    endcase
  end

  assign sin_ref = rom_ref(angle);
  assign cos_ref = rom_ref(angle + QUARTER_TURN);

  // Table reads, two per cycle while the back end advances, registered
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sin_mag_q <= SINE_ROM[sin_ref[ADDR_W-1:0]];
      cos_mag_q <= SINE_ROM[cos_ref[ADDR_W-1:0]];
      sin_neg_q <= sin_ref[ADDR_W];
      cos_neg_q <= cos_ref[ADDR_W];
    end
  end

  assign sin_val = apply_sign(sin_neg_q, sin_mag_q);
  assign cos_val = apply_sign(cos_neg_q, cos_mag_q);

  // Collect the first three slots of the quad
  always_ff @(posedge clk_i) begin
    if (adv_i && rd_valid_q) begin
      case (rd_slot_q)
        SLOT_AZ0: begin
          sa0_q <= sin_val;
          ca0_q <= cos_val;
        end
        SLOT_POL0: begin
          sp0_q <= sin_val;
          cp0_q <= cos_val;
        end
        SLOT_POL1: begin
          sp1_q <= sin_val;
          cp1_q <= cos_val;
        end
        default: begin
        end
      endcase
    end
  end

  // Hand the full set over with the last slot
  assign trig_o.load    = adv_i && rd_valid_q && (rd_slot_q == SLOT_AZ1);
  assign trig_o.set.sp0 = sp0_q;
  assign trig_o.set.cp0 = cp0_q;
  assign trig_o.set.sp1 = sp1_q;
  assign trig_o.set.cp1 = cp1_q;
  assign trig_o.set.sa0 = sa0_q;
  assign trig_o.set.ca0 = ca0_q;
  assign trig_o.set.sa1 = sin_val;
  assign trig_o.set.ca1 = cos_val;

endmodule

`default_nettype wire

FILE: src/sqvg_vertex.sv
// ----------------------------------------------------------------------------
// sqvg_vertex: corner sequencer and vertex datapath
// Steps through the four corners of a quad, scales by the radius, forms
// x, y and z with rounding and saturation, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_vertex (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [sqvg_pkg::RADIUS_W-1:0]      radius_i,
  input  wire sqvg_pkg::trig_load_t               trig_i,
  output logic                                    adv_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [sqvg_pkg::CORNER_W-1:0]           corner_o,
  output logic signed [sqvg_pkg::COORD_W-1:0]     coord_x_o,
  output logic signed [sqvg_pkg::COORD_W-1:0]     coord_y_o,
  output logic signed [sqvg_pkg::COORD_W-1:0]     coord_z_o,
  output logic                                    last_o
);

  localparam int COORD_W  = sqvg_pkg::COORD_W;
  localparam int CORNER_W = sqvg_pkg::CORNER_W;
  localparam int RS_W     = 2 * COORD_W;
  localparam int PROD_W   = RS_W + COORD_W;
  localparam int RND_W    = PROD_W + 1;
  localparam int LIM_W    = COORD_W + 1;
  localparam int SHIFT_W  = $clog2(PROD_W);

  localparam logic [LIM_W-1:0]   NEG_LIMIT = LIM_W'(1) << (COORD_W - 1);
  localparam logic [LIM_W-1:0]   POS_LIMIT = NEG_LIMIT - 1'b1;
  localparam logic [SHIFT_W-1:0] XY_SHIFT  = SHIFT_W'(30);
  localparam logic [SHIFT_W-1:0] Z_SHIFT   = SHIFT_W'(15);

  sqvg_pkg::trig_set_t       work_q;
  logic                      work_valid_q;
  logic                      work_valid_d;
  logic [CORNER_W-1:0]       corner_q;
  logic [CORNER_W-1:0]       corner_d;
  logic                      use_p1;
  sqvg_pkg::trig_val_t       sp;
  sqvg_pkg::trig_val_t       cp;
  sqvg_pkg::trig_val_t       sa;
  sqvg_pkg::trig_val_t       ca;
  logic signed [COORD_W-1:0] radius_s;
  logic signed [RS_W-1:0]    rs;
  logic signed [RS_W-1:0]    rc;
  logic                      a_valid_q;
  logic [CORNER_W-1:0]       a_corner_q;
  logic signed [RS_W-1:0]    a_rs_q;
  logic signed [RS_W-1:0]    a_rc_q;
  sqvg_pkg::trig_val_t       a_sa_q;
  sqvg_pkg::trig_val_t       a_ca_q;
  logic signed [PROD_W-1:0]  xp;
  logic signed [PROD_W-1:0]  yp;
  logic                      b_valid_q;
  logic [CORNER_W-1:0]       b_corner_q;
  logic signed [PROD_W-1:0]  b_xp_q;
  logic signed [PROD_W-1:0]  b_yp_q;
  logic [COORD_W-1:0]        b_z_q;
  logic                      out_valid_q;
  logic [CORNER_W-1:0]       out_corner_q;
  logic [COORD_W-1:0]        out_x_q;
  logic [COORD_W-1:0]        out_y_q;
  logic [COORD_W-1:0]        out_z_q;

  // Round half away from zero, then saturate to the coordinate range
  function automatic logic [COORD_W-1:0] round_sat(input logic signed [PROD_W-1:0] prod,
                                                   input logic [SHIFT_W-1:0] shift);
    logic [PROD_W-1:0] mag;
    logic [RND_W-1:0]  rnd;
    logic [LIM_W-1:0]  lim;
    mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    rnd = (RND_W'(mag) + (RND_W'(1) << (shift - 1'b1))) >> shift;
    if (prod[PROD_W-1]) begin
      lim = (rnd > RND_W'(NEG_LIMIT)) ? NEG_LIMIT : rnd[LIM_W-1:0];
      return COORD_W'(LIM_W'(0) - lim);
    end
    lim = (rnd > RND_W'(POS_LIMIT)) ? POS_LIMIT : rnd[LIM_W-1:0];
    return lim[COORD_W-1:0];
  endfunction

  // Whole back end moves when the result register is free or drained
  assign adv_o = !out_valid_q || !out_stall_i;

  // Corner sequencer
  always_comb begin
    work_valid_d = work_valid_q;
    corner_d     = corner_q;
    if (adv_o && work_valid_q) begin
      corner_d = corner_q + 1'b1;
      if (corner_q == sqvg_pkg::LAST_CORNER) begin
        work_valid_d = 1'b0;
      end
    end
    if (trig_i.load) begin
      work_valid_d = 1'b1;
      corner_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      corner_q     <= '0;
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      corner_q     <= corner_d;
      if (adv_o) begin
        a_valid_q   <= work_valid_q;
        b_valid_q   <= a_valid_q;
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (trig_i.load) begin
      work_q <= trig_i.set;
    end
  end

  // Corners 1 and 2 use the next ring, corners 2 and 3 the next segment
  assign use_p1 = corner_q[0] ^ corner_q[1];
  assign sp = use_p1 ? work_q.sp1 : work_q.sp0;
  assign cp = use_p1 ? work_q.cp1 : work_q.cp0;
  assign sa = corner_q[1] ? work_q.sa1 : work_q.sa0;
  assign ca = corner_q[1] ? work_q.ca1 : work_q.ca0;

  assign radius_s = signed'({1'b0, radius_i});
  assign rs = RS_W'(radius_s) * RS_W'(sp);
  assign rc = RS_W'(radius_s) * RS_W'(cp);

  // Radius scaling stage
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      a_corner_q <= corner_q;
      a_rs_q     <= rs;
      a_rc_q     <= rc;
      a_sa_q     <= sa;
      a_ca_q     <= ca;
    end
  end

  assign xp = PROD_W'(a_rs_q) * PROD_W'(a_ca_q);
  assign yp = PROD_W'(a_rs_q) * PROD_W'(a_sa_q);

  // Azimuth product stage
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      b_corner_q <= a_corner_q;
      b_xp_q     <= xp;
      b_yp_q     <= yp;
      b_z_q      <= round_sat(PROD_W'(a_rc_q), Z_SHIFT);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_corner_q <= b_corner_q;
      out_x_q      <= round_sat(b_xp_q, XY_SHIFT);
      out_y_q      <= round_sat(b_yp_q, XY_SHIFT);
      out_z_q      <= b_z_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corner_o    = out_corner_q;
  assign coord_x_o   = signed'(out_x_q);
  assign coord_y_o   = signed'(out_y_q);
  assign coord_z_o   = signed'(out_z_q);
  assign last_o      = (out_corner_q == sqvg_pkg::LAST_CORNER);

endmodule

`default_nettype wire

FILE: src/sphere_quad_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// sphere_quad_vertex_generator_unit: UV sphere quad vertex generator
// Takes a ring and segment index and emits the quad's four corner vertices
// (x, y, z in signed Q1.15) through a front end, a queue and a back end.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o| ring_index_i, segment_index_i
//  out     | output    | out_valid_o/out_stall_i| corner_o, coord_x/y/z_o, last_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  The back end emits one vertex per cycle while the output is not stalled,
//  and the sine table's two read ports fetch the quad's 8 values.
//  Reset clears all control state at once and loads the register defaults;
//  there is no clearing pass. The table is a constant ROM.
//  A stalled output freezes the back end; the 2-entry queue keeps taking items until full.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_quad_vertex_generator_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [sqvg_pkg::INDEX_BITS-1:0]     ring_index_i,
  input  wire logic [sqvg_pkg::INDEX_BITS-1:0]     segment_index_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [sqvg_pkg::CORNER_W-1:0]            corner_o,
  output logic signed [sqvg_pkg::COORD_W-1:0]      coord_x_o,
  output logic signed [sqvg_pkg::COORD_W-1:0]      coord_y_o,
  output logic signed [sqvg_pkg::COORD_W-1:0]      coord_z_o,
  output logic                                     last_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [sqvg_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [sqvg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [sqvg_pkg::RADIUS_W-1:0] radius;
  logic                          q_full;
  logic                          q_push;
  sqvg_pkg::angles_t             q_push_data;
  logic                          q_pop;
  logic                          q_head_valid;
  sqvg_pkg::angles_t             q_head_data;
  logic                          adv;
  sqvg_pkg::trig_load_t          trig;

  sqvg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .ring_index_i    (ring_index_i),
    .segment_index_i (segment_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .radius_o        (radius),
    .queue_full_i    (q_full),
    .push_o          (q_push),
    .push_data_o     (q_push_data)
  );

  sqvg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_push_data),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_data_o  (q_head_data)
  );

  sqvg_lookup u_lookup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .head_valid_i (q_head_valid),
    .head_data_i  (q_head_data),
    .pop_o        (q_pop),
    .trig_o       (trig)
  );

  sqvg_vertex u_vertex (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius),
    .trig_i      (trig),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .corner_o    (corner_o),
    .coord_x_o   (coord_x_o),
    .coord_y_o   (coord_y_o),
    .coord_z_o   (coord_z_o),
    .last_o      (last_o)
  );

  // Lookup pops only a queue that holds a record
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

  // Input stall rises only after an item was taken into the queue
  a_stall_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stall rose without a queued item");

  // A hand-over to the vertex stage happens only when the back end advances
  a_load_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig.load |-> adv)
    else $error("trig set loaded while back end stalled");

  // Last flag marks the final corner only
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> corner_o == sqvg_pkg::LAST_CORNER)
    else $error("last flag on a corner other than the final one");

endmodule

`default_nettype wire

FILE: dv/sphere_quad_vertex_generator_unit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sphere_quad_vertex_generator_unit_chk: vertex checker of the quad generator
// Watches the quad, vertex and register channels, keeps its own copy of the
// sphere geometry and of the quarter-wave sine table, predicts the four
// corner vertices of every quad taken and compares each vertex sent, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sphere_quad_vertex_generator_unit_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [sqvg_pkg::INDEX_BITS-1:0]      ring_index_i,
  input  logic [sqvg_pkg::INDEX_BITS-1:0]      segment_index_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [sqvg_pkg::CORNER_W-1:0]        corner_i,
  input  logic signed [sqvg_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [sqvg_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [sqvg_pkg::COORD_W-1:0]  coord_z_i,
  input  logic                                 last_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [sqvg_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [sqvg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output int                                   quads_done_o,
  output int                                   failures_o
);

  localparam int ANGLE_W  = sqvg_pkg::ANGLE_W;
  localparam int COORD_W  = sqvg_pkg::COORD_W;
  localparam int CORNER_W = sqvg_pkg::CORNER_W;
  localparam int MAG_W    = sqvg_pkg::MAG_W;
  localparam int DEPTH    = sqvg_pkg::SINE_TABLE_DEPTH;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam int                 REPORT_MAX   = 10;

  typedef struct packed {
    logic [CORNER_W-1:0]       corner;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } vertex_t;

  vertex_t                       expected_vertices [$];
  logic [MAG_W-1:0]              quarter_sine [0:DEPTH];
  logic [sqvg_pkg::RADIUS_W-1:0] radius_q;
  logic [ANGLE_W-1:0]            polar_step_q;
  logic [ANGLE_W-1:0]            azimuth_step_q;
  int                            mismatches;

  // Fill the quarter-wave table: Taylor series to the 11th power in Q30
  initial begin : build_quarter_sine
    longint unsigned arg;
    longint unsigned arg_sq;
    longint unsigned term;
    longint unsigned scaled;
    longint          acc;
    for (int k = 0; k <= DEPTH; k++) begin
      arg    = (longint'(k) * sqvg_pkg::HALF_PI_Q30) / longint'(DEPTH);
      arg_sq = (arg * arg) >> 30;
      term   = arg;
      acc    = longint'(arg);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * arg_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) begin
        acc = 0;
      end
      scaled = (longint'(acc) * 32768 + (longint'(1) << 29)) >> 30;
      quarter_sine[k] = (scaled > 32767) ? MAG_W'(32767) : MAG_W'(scaled);
    end
  end

  // Signed sine of an angle in 2^-16 turn units
  function automatic int table_sine(logic [ANGLE_W-1:0] ang);
    int slot;
    int mag;
    slot = (int'(ang[13:0]) * DEPTH) >> 14;
    if (slot > DEPTH) begin
      slot = DEPTH;
    end
    mag = ang[14] ? int'(quarter_sine[DEPTH - slot]) : int'(quarter_sine[slot]);
    return ang[15] ? -mag : mag;
  endfunction

  function automatic int table_cosine(logic [ANGLE_W-1:0] ang);
    logic [ANGLE_W-1:0] turned;
    turned = ang + QUARTER_TURN;
    return table_sine(turned);
  endfunction

  // Scale down with halves away from zero, then clamp to Q1.15
  function automatic logic signed [COORD_W-1:0] round_q15(longint prod, int shift);
    longint mag;
    bit     neg;
    neg = prod < 0;
    mag = neg ? -prod : prod;
    mag = (mag + (longint'(1) << (shift - 1))) >> shift;
    if (neg) begin
      if (mag > 32768) begin
        mag = 32768;
      end
      return COORD_W'(-mag);
    end
    if (mag > 32767) begin
      mag = 32767;
    end
    return COORD_W'(mag);
  endfunction

  // Queue the four corners of one quad in emission order
  function automatic void predict_quad(logic [sqvg_pkg::INDEX_BITS-1:0] ring,
                                       logic [sqvg_pkg::INDEX_BITS-1:0] seg);
    logic [ANGLE_W-1:0] pol [4];
    logic [ANGLE_W-1:0] azi [4];
    logic [ANGLE_W-1:0] p0;
    logic [ANGLE_W-1:0] a0;
    longint             r_sin;
    longint             r_cos;
    vertex_t            v;
    p0     = ANGLE_W'(32'(ring) * 32'(polar_step_q));
    a0     = ANGLE_W'(32'(seg) * 32'(azimuth_step_q));
    pol[0] = p0;
    pol[1] = p0 + polar_step_q;
    pol[2] = p0 + polar_step_q;
    pol[3] = p0;
    azi[0] = a0;
    azi[1] = a0;
    azi[2] = a0 + azimuth_step_q;
    azi[3] = a0 + azimuth_step_q;
    for (int c = 0; c < 4; c++) begin
      r_sin    = longint'(radius_q) * longint'(table_sine(pol[c]));
      r_cos    = longint'(radius_q) * longint'(table_cosine(pol[c]));
      v.corner = CORNER_W'(c);
      v.x      = round_q15(r_sin * longint'(table_cosine(azi[c])), 30);
      v.y      = round_q15(r_sin * longint'(table_sine(azi[c])), 30);
      v.z      = round_q15(r_cos, 15);
      v.last   = (CORNER_W'(c) == sqvg_pkg::LAST_CORNER);
      expected_vertices.push_back(v);
    end
  endfunction

  // Track geometry, predict on each quad taken, compare each vertex taken
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t want;
    vertex_t got;
    if (!rst_ni) begin
      radius_q       <= sqvg_pkg::RADIUS_RESET;
      polar_step_q   <= sqvg_pkg::POLAR_STEP_RESET;
      azimuth_step_q <= sqvg_pkg::AZIMUTH_STEP_RESET;
      expected_vertices.delete();
      mismatches = 0;
      quads_done_o <= 0;
      failures_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.corner = corner_i;
        got.x      = coord_x_i;
        got.y      = coord_y_i;
        got.z      = coord_z_i;
        got.last   = last_i;
        if (expected_vertices.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: vertex with no quad pending: corner %0d x %0d y %0d z %0d last %0d",
                     $time, got.corner, $signed(got.x), $signed(got.y), $signed(got.z),
                     got.last);
          end
          mismatches++;
        end else begin
          want = expected_vertices.pop_front();
          if (want.last) begin
            quads_done_o <= quads_done_o + 1;
          end
          if (got.corner !== want.corner || got.x !== want.x || got.y !== want.y ||
              got.z !== want.z || got.last !== want.last) begin
            if (mismatches < REPORT_MAX) begin
              $display("%0t: vertex mismatch: expected corner %0d x %0d y %0d z %0d last %0d",
                       $time, want.corner, $signed(want.x), $signed(want.y),
                       $signed(want.z), want.last);
              $display("%0t:                  got      corner %0d x %0d y %0d z %0d last %0d",
                       $time, got.corner, $signed(got.x), $signed(got.y),
                       $signed(got.z), got.last);
            end
            mismatches++;
          end
        end
      end
      // Unknown register indexes leave the geometry alone
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          sqvg_pkg::REG_RADIUS: begin
            radius_q <= cfg_data_i[sqvg_pkg::RADIUS_W-1:0];
          end
          sqvg_pkg::REG_POLAR_STEP: begin
            polar_step_q <= cfg_data_i[ANGLE_W-1:0];
          end
          sqvg_pkg::REG_AZIMUTH_STEP: begin
            azimuth_step_q <= cfg_data_i[ANGLE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_quad(ring_index_i, segment_index_i);
      end
      // Vertices still owed count against the run once it has ended
      failures_o <= mismatches + expected_vertices.size();
    end
  end

endmodule

FILE: dv/sphere_quad_vertex_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sphere_quad_vertex_generator_unit_tb: testbench of the quad vertex generator
// Resets the block, sends directed quads at the geometry extremes and then
// random quads under several radius and step settings, with random gaps and
// stalls on both channels and one long output hold. A checker beside the
// block predicts and compares every vertex; this module gives the verdict.
// ----------------------------------------------------------------------------
module sphere_quad_vertex_generator_unit_tb;

  localparam int INDEX_BITS  = sqvg_pkg::INDEX_BITS;
  localparam int CFG_INDEX_W = sqvg_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = sqvg_pkg::CFG_DATA_W;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE      = 2'd3;
  localparam int                     WATCHDOG_LIMIT = 2000;
  localparam int                     HOLD_CYCLES    = 64;
  localparam int                     SETTLE_CYCLES  = 32;
  localparam int                     PHASE_ITEMS    = 55;
  localparam int                     RECONFIG_EVERY = 20;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [INDEX_BITS-1:0]                ring_index_i;
  logic [INDEX_BITS-1:0]                segment_index_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic [sqvg_pkg::CORNER_W-1:0]        corner_o;
  logic signed [sqvg_pkg::COORD_W-1:0]  coord_x_o;
  logic signed [sqvg_pkg::COORD_W-1:0]  coord_y_o;
  logic signed [sqvg_pkg::COORD_W-1:0]  coord_z_o;
  logic                                 last_o;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic [CFG_INDEX_W-1:0]               cfg_index_i;
  logic [CFG_DATA_W-1:0]                cfg_data_i;

  int quads_sent;
  int quads_done;
  int failures;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;

  sphere_quad_vertex_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .ring_index_i    (ring_index_i),
    .segment_index_i (segment_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .corner_o        (corner_o),
    .coord_x_o       (coord_x_o),
    .coord_y_o       (coord_y_o),
    .coord_z_o       (coord_z_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  sphere_quad_vertex_generator_unit_chk checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .ring_index_i    (ring_index_i),
    .segment_index_i (segment_index_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .corner_i        (corner_o),
    .coord_x_i       (coord_x_o),
    .coord_y_i       (coord_y_o),
    .coord_z_i       (coord_z_o),
    .last_i          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .quads_done_o    (quads_done),
    .failures_o      (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one quad after a random gap and hold it until taken
  task automatic send_quad(input logic [INDEX_BITS-1:0] ring,
                           input logic [INDEX_BITS-1:0] seg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    ring_index_i    <= ring;
    segment_index_i <= seg;
    do @(posedge clk_i); while (in_stall_o);
    quads_sent++;
  endtask

  // Drop the offer and hold off new quads until every vertex owed has come out
  task automatic drain_quads();
    in_valid_i <= 1'b0;
    wait (quads_done == quads_sent);
  endtask

  // Write radius and both steps back to back, optionally after a stray index
  task automatic program_sphere(input logic [CFG_DATA_W-1:0] radius_word,
                                input logic [CFG_DATA_W-1:0] polar,
                                input logic [CFG_DATA_W-1:0] azimuth,
                                input bit                    add_stray);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    idx[0] = REG_SPARE;
    val[0] = CFG_DATA_W'($urandom());
    idx[1] = sqvg_pkg::REG_RADIUS;
    val[1] = radius_word;
    idx[2] = sqvg_pkg::REG_POLAR_STEP;
    val[2] = polar;
    idx[3] = sqvg_pkg::REG_AZIMUTH_STEP;
    val[3] = azimuth;
    for (int i = 0; i < 4; i++) begin
      if (i > 0 || add_stray) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= idx[i];
        cfg_data_i  <= val[i];
        do @(posedge clk_i); while (!cfg_ready_o);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_index();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return INDEX_BITS'($urandom_range(15));
      default: return INDEX_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_radius_word();
    case ($urandom_range(3))
      0:       return 16'h7FFF;
      1:       return 16'hFFFF;
      2:       return CFG_DATA_W'($urandom_range(2047));
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(4))
      0:       return CFG_DATA_W'(32'd65536 / $urandom_range(512, 3));
      1:       return '1;
      2:       return '0;
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  // Output side: random stalls, plus one long hold when asked
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // End the run when no channel has moved for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    ring_index_i    <= '0;
    segment_index_i <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    quads_sent    = 0;
    hold_request  = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 70;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: index extremes and alternating bit patterns
    send_quad(10'd0, 10'd0);
    send_quad(10'd1023, 10'd1023);
    send_quad(10'd0, 10'd1023);
    send_quad(10'd1023, 10'd0);
    send_quad(10'h155, 10'h2AA);
    send_quad(10'h2AA, 10'h155);

    // Full radius, quarter-turn steps: angles land on quadrant edges
    drain_quads();
    program_sphere(16'h7FFF, 16'h4000, 16'h4000, 1'b1);
    send_quad(10'd0, 10'd0);
    send_quad(10'd1, 10'd1);
    send_quad(10'd2, 10'd3);
    send_quad(10'd3, 10'd2);

    // Largest steps: polar past a half turn and wrap of both angles;
    // the radius word carries a top bit that the register drops
    drain_quads();
    program_sphere(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_quad(10'd1023, 10'd1023);
    send_quad(10'd0, 10'd0);
    send_quad(10'd1, 10'd512);

    // Zero radius and zero steps
    drain_quads();
    program_sphere(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_quad(10'd17, 10'd900);

    // A stray register index must leave the geometry untouched
    drain_quads();
    program_sphere(16'd12345, 16'd1000, 16'd3000, 1'b0);
    program_sphere(16'd0, 16'd0, 16'd0, 1'b1);
    program_sphere(16'd12345, 16'd1000, 16'd3000, 1'b1);
    send_quad(10'd100, 10'd200);

    // Random quads under three idle patterns, regeometry every 20 quads
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % RECONFIG_EVERY == 0) begin
          drain_quads();
          program_sphere(pick_radius_word(), pick_step(), pick_step(),
                         bit'($urandom_range(1)));
        end
        // Long output hold while quads keep coming, to back up the input
        if (phase == 2 && n == 25) begin
          hold_request = 1'b1;
        end
        send_quad(pick_index(), pick_index());
      end
    end

    drain_quads();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
